// ----- design/dbpf_pkg.sv -----
package dbpf_pkg;

   // Table and coordinate format
   localparam int MaxClasses    = 128;
   localparam int CoordFracBits = 4;
   localparam int ClassAddrW    = $clog2(MaxClasses);
   localparam int NetW          = 12;
   localparam int CoordW        = NetW + CoordFracBits;
   localparam int PadW          = (CoordW > 16) ? CoordW : 16;
   localparam int FracW         = 16;
   localparam int ProdW         = FracW + CoordW;
   localparam int XyW           = 20;
   localparam int ScoreW        = 17;
   localparam int ClassW        = 16;
   localparam int OutW          = 16;
   localparam int ClassOutW     = 7;
   localparam int CsrIndexW     = 3;
   localparam int CsrDataW      = 16;
   localparam int ReqDataW      = 120;
   localparam int RspDataW      = 88;

   localparam logic CmdDetect = 1'b0;
   localparam logic CmdThresh = 1'b1;

   typedef enum logic [1:0] {
      PadNone  = 2'd0,
      PadFixed = 2'd1,
      PadFrame = 2'd2,
      PadBox   = 2'd3
   } pad_mode_type;

   typedef enum logic [CsrIndexW-1:0] {
      CsrNetWidth    = 3'd0,
      CsrNetHeight   = 3'd1,
      CsrPadMode     = 3'd2,
      CsrPadPixels   = 3'd3,
      CsrPadFraction = 3'd4,
      CsrNumClasses  = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [NetW-1:0] net_width;
      logic [NetW-1:0] net_height;
      pad_mode_type    pad_mode;
      logic [15:0]     margin_px;
      logic [FracW-1:0] pad_fraction;
      logic [7:0]      num_classes;
   } cfg_type;

   localparam cfg_type CfgRst = '{
      net_width:    NetW'(640),
      net_height:   NetW'(640),
      pad_mode:     PadBox,
      margin_px:    16'd480,
      pad_fraction: 16'd9830,
      num_classes:  8'd80
   };

   typedef struct packed {
      logic                     cmd;
      logic signed [XyW-1:0]    x_start;
      logic signed [XyW-1:0]    y_start;
      logic signed [XyW-1:0]    x_end;
      logic signed [XyW-1:0]    y_end;
      logic [ScoreW-1:0]        score;
      logic signed [ClassW-1:0] class_index;
      logic                     end_of_frame;
   } req_type;

   typedef struct packed {
      logic                 pass;
      logic [CoordW-1:0]    x1;
      logic [CoordW-1:0]    y1;
      logic [CoordW-1:0]    x2;
      logic [CoordW-1:0]    y2;
      logic [PadW-1:0]      pad;
      logic [ClassOutW-1:0] class_out;
      logic [ScoreW-1:0]    confidence;
      logic                 eof;
   } mid_type;

   typedef struct packed {
      logic                 kept;
      logic [OutW-1:0]      box_left;
      logic [OutW-1:0]      box_top;
      logic [OutW-1:0]      box_width;
      logic [OutW-1:0]      box_height;
      logic [ClassOutW-1:0] class_out;
      logic [ScoreW-1:0]    confidence;
      logic                 frame_done;
   } rsp_type;

   // Frame size in pixels to a coordinate limit with fraction bits
   function automatic logic [CoordW-1:0] coord_limit(input logic [NetW-1:0] net);
      coord_limit = {net, {CoordFracBits{1'b0}}};
   endfunction

   // Whether a class index names a table row
   function automatic logic class_in_table(input logic signed [ClassW-1:0] cls);
      class_in_table = !cls[ClassW-1] &&
                       ({1'b0, cls[ClassW-2:0]} < ClassW'(MaxClasses));
   endfunction

endpackage

// ----- design/detection_box_pad_filter_top.sv -----
// Channel    Dir  Handshake              Payload
// req_       in   req_tvalid/req_tready  tdata: box corners, score, class; tuser: cmd;
//                                        tlast: end_of_frame
// rsp_       out  rsp_tvalid/rsp_tready  tdata: padded box, class, confidence; tuser: kept;
//                                        tlast: frame_done
// csr_       in   csr_we (no wait)       csr_index selects the register, csr_wdata the value
//
// One request per cycle sustained while rsp_tready does not stall; each result passes the input
// register with threshold RAM read, the clip/margin register and the result register.
// Reset restores the register defaults and clears the threshold valid bits at once, so
// there is no clearing pass: an unwritten class reads a threshold of zero.
// A stalled rsp_tready holds every stage; the pipeline still fills its empty stages.
module detection_box_pad_filter_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [19:0] x_start, [39:20] y_start, [59:40] x_end, [79:60] y_end,
   // [96:80] score, [112:97] class_index, [119:113] zero
   input  logic [dbpf_pkg::ReqDataW-1:0]     req_tdata,
   // [0] cmd
   input  logic                              req_tuser,
   input  logic                              req_tlast,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [15:0] box_left, [31:16] box_top, [47:32] box_width, [63:48] box_height,
   // [70:64] class_out, [87:71] confidence
   output logic [dbpf_pkg::RspDataW-1:0]     rsp_tdata,
   // [0] kept
   output logic                              rsp_tuser,
   output logic                              rsp_tlast,
   input  logic                              csr_we,
   input  logic [dbpf_pkg::CsrIndexW-1:0]    csr_index,
   input  logic [dbpf_pkg::CsrDataW-1:0]     csr_wdata
);

   dbpf_pkg::cfg_type cfg_ff, cfg_in;
   dbpf_pkg::req_type req_in, req_ff;
   dbpf_pkg::mid_type mid_in, mid_ff;
   dbpf_pkg::rsp_type rsp_in, rsp_ff;

   logic s1_vld_ff, s1_vld_in, s2_vld_ff, s2_vld_in, s3_vld_ff, s3_vld_in;
   logic adv1, adv2, adv3, accept;

   logic                              ram_we;
   logic [dbpf_pkg::ClassAddrW-1:0]   ram_addr;
   logic [dbpf_pkg::ScoreW-1:0]       ram_rdata;
   logic [dbpf_pkg::ScoreW-1:0]       thr;
   logic [dbpf_pkg::MaxClasses-1:0]   thr_valid_ff, thr_valid_in;
   logic                              thr_hit_ff, thr_hit_in;

   // Unpack the request
   always_comb begin
      req_in.cmd          = req_tuser;
      req_in.x_start      = req_tdata[19:0];
      req_in.y_start      = req_tdata[39:20];
      req_in.x_end        = req_tdata[59:40];
      req_in.y_end        = req_tdata[79:60];
      req_in.score        = req_tdata[96:80];
      req_in.class_index  = req_tdata[112:97];
      req_in.end_of_frame = req_tlast;
   end

   // Advance a stage when its slot is empty or the next one moves
   assign adv3       = !s3_vld_ff || rsp_tready;
   assign adv2       = !s2_vld_ff || adv3;
   assign adv1       = !s1_vld_ff || adv2;
   assign req_tready = adv1;
   assign accept     = req_tvalid && req_tready;

   assign s1_vld_in = adv1 ? req_tvalid : s1_vld_ff;
   assign s2_vld_in = adv2 ? s1_vld_ff : s2_vld_ff;
   assign s3_vld_in = adv3 ? s2_vld_ff : s3_vld_ff;

   // Register writes: ignore indexes past the list
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            dbpf_pkg::CsrNetWidth:    cfg_in.net_width    = csr_wdata[dbpf_pkg::NetW-1:0];
            dbpf_pkg::CsrNetHeight:   cfg_in.net_height   = csr_wdata[dbpf_pkg::NetW-1:0];
            dbpf_pkg::CsrPadMode:     cfg_in.pad_mode     = dbpf_pkg::pad_mode_type'(csr_wdata[1:0]);
            dbpf_pkg::CsrPadPixels:   cfg_in.margin_px    = csr_wdata[15:0];
            dbpf_pkg::CsrPadFraction: cfg_in.pad_fraction = csr_wdata[dbpf_pkg::FracW-1:0];
            dbpf_pkg::CsrNumClasses:  cfg_in.num_classes  = csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   // Threshold table: write on a threshold request, read for every request.
   // Both happen at accept, so a following request always sees the new value.
   assign ram_addr = req_in.class_index[dbpf_pkg::ClassAddrW-1:0];
   assign ram_we   = accept && (req_in.cmd == dbpf_pkg::CmdThresh) &&
                     dbpf_pkg::class_in_table(req_in.class_index);

   dbpf_ram #(
      .Width (dbpf_pkg::ScoreW),
      .Depth (dbpf_pkg::MaxClasses)
   ) u_thr_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_addr),
      .wdata (req_in.score),
      .re    (accept),
      .raddr (ram_addr),
      .rdata (ram_rdata)
   );

   // Valid bits stand in for the reset value of never-written rows
   always_comb begin
      for (int i = 0; i < dbpf_pkg::MaxClasses; i++) begin
         thr_valid_in[i] = thr_valid_ff[i] ||
                           (ram_we && (ram_addr == dbpf_pkg::ClassAddrW'(i)));
      end
   end

   assign thr_hit_in = accept ? thr_valid_ff[ram_addr] : thr_hit_ff;
   assign thr        = thr_hit_ff ? ram_rdata : '0;

   // Stage 2: class check, threshold, clamp, margin
   dbpf_clip u_clip (
      .cfg (cfg_ff),
      .req (req_ff),
      .thr (thr),
      .mid (mid_in)
   );

   // Stage 3: apply the margin, clamp again, size check
   dbpf_pad u_pad (
      .cfg (cfg_ff),
      .mid (mid_ff),
      .rsp (rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff       <= dbpf_pkg::CfgRst;
         s1_vld_ff    <= 1'b0;
         s2_vld_ff    <= 1'b0;
         s3_vld_ff    <= 1'b0;
         thr_valid_ff <= '0;
         thr_hit_ff   <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         s1_vld_ff    <= s1_vld_in;
         s2_vld_ff    <= s2_vld_in;
         s3_vld_ff    <= s3_vld_in;
         thr_valid_ff <= thr_valid_in;
         thr_hit_ff   <= thr_hit_in;
      end
   end

   // Payload registers: load when the stage advances, otherwise hold
   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_in;
      end
      if (adv2) begin
         mid_ff <= mid_in;
      end
      if (adv3) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_tvalid = s3_vld_ff;
   assign rsp_tdata  = {rsp_ff.confidence, rsp_ff.class_out, rsp_ff.box_height,
                        rsp_ff.box_width, rsp_ff.box_top, rsp_ff.box_left};
   assign rsp_tuser  = rsp_ff.kept;
   assign rsp_tlast  = rsp_ff.frame_done;

endmodule

// ----- design/dbpf_ram.sv -----
module dbpf_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(Depth)-1:0] waddr,
   input  logic [Width-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(Depth)-1:0] raddr,
   output logic [Width-1:0]         rdata
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ----- design/dbpf_clip.sv -----
module dbpf_clip (
   input  dbpf_pkg::cfg_type            cfg,
   input  dbpf_pkg::req_type            req,
   input  logic [dbpf_pkg::ScoreW-1:0]  thr,
   output dbpf_pkg::mid_type            mid
);

   function automatic logic [dbpf_pkg::CoordW-1:0] clamp_coord(
      input logic signed [dbpf_pkg::XyW-1:0] v,
      input logic [dbpf_pkg::CoordW-1:0]     lim
   );
      logic signed [dbpf_pkg::XyW:0] vs;
      logic signed [dbpf_pkg::XyW:0] ls;
      vs = {v[dbpf_pkg::XyW-1], v};
      ls = $signed({{(dbpf_pkg::XyW + 1 - dbpf_pkg::CoordW){1'b0}}, lim});
      if (vs < 0) begin
         clamp_coord = '0;
      end else if (vs > ls) begin
         clamp_coord = lim;
      end else begin
         clamp_coord = vs[dbpf_pkg::CoordW-1:0];
      end
   endfunction

   logic [dbpf_pkg::CoordW-1:0] limw, limh, x1, y1, x2, y2, w, h, opnd;
   logic [dbpf_pkg::ProdW-1:0]  prod;
   logic [dbpf_pkg::ClassW-1:0] cls_mag;
   logic                        cls_ok;

   always_comb begin
      limw = dbpf_pkg::coord_limit(cfg.net_width);
      limh = dbpf_pkg::coord_limit(cfg.net_height);
      x1 = clamp_coord(req.x_start, limw);
      y1 = clamp_coord(req.y_start, limh);
      x2 = clamp_coord(req.x_end, limw);
      y2 = clamp_coord(req.y_end, limh);
      w = (x2 > x1) ? x2 - x1 : '0;
      h = (y2 > y1) ? y2 - y1 : '0;

      // one shared multiplier: frame side for frame mode, box side otherwise
      if (cfg.pad_mode == dbpf_pkg::PadFrame) begin
         opnd = (limw > limh) ? limw : limh;
      end else begin
         opnd = (w > h) ? w : h;
      end
      prod = dbpf_pkg::ProdW'(cfg.pad_fraction) * dbpf_pkg::ProdW'(opnd);

      case (cfg.pad_mode)
         dbpf_pkg::PadFixed: mid.pad = dbpf_pkg::PadW'(cfg.margin_px);
         dbpf_pkg::PadFrame,
         dbpf_pkg::PadBox:   mid.pad = dbpf_pkg::PadW'(prod[dbpf_pkg::ProdW-1:dbpf_pkg::FracW]);
         default:            mid.pad = '0;
      endcase

      // drop negative classes and classes past the active count
      cls_mag = {1'b0, req.class_index[dbpf_pkg::ClassW-2:0]};
      cls_ok  = dbpf_pkg::class_in_table(req.class_index) &&
                (cls_mag < dbpf_pkg::ClassW'(cfg.num_classes));

      mid.pass       = (req.cmd == dbpf_pkg::CmdDetect) && cls_ok && (req.score >= thr);
      mid.x1         = x1;
      mid.y1         = y1;
      mid.x2         = x2;
      mid.y2         = y2;
      mid.class_out  = req.class_index[dbpf_pkg::ClassOutW-1:0];
      mid.confidence = req.score;
      mid.eof        = req.end_of_frame;
   end

endmodule

// ----- design/dbpf_pad.sv -----
module dbpf_pad (
   input  dbpf_pkg::cfg_type cfg,
   input  dbpf_pkg::mid_type mid,
   output dbpf_pkg::rsp_type rsp
);

   logic [dbpf_pkg::CoordW-1:0] limw, limh, nx1, ny1, nx2, ny2, bw, bh;
   logic [dbpf_pkg::PadW:0]     sx, sy;
   logic                        kept;

   always_comb begin
      limw = dbpf_pkg::coord_limit(cfg.net_width);
      limh = dbpf_pkg::coord_limit(cfg.net_height);

      // start corner moves down toward zero, floor at zero
      nx1 = (dbpf_pkg::PadW'(mid.x1) >= mid.pad) ?
            dbpf_pkg::CoordW'(dbpf_pkg::PadW'(mid.x1) - mid.pad) : '0;
      ny1 = (dbpf_pkg::PadW'(mid.y1) >= mid.pad) ?
            dbpf_pkg::CoordW'(dbpf_pkg::PadW'(mid.y1) - mid.pad) : '0;

      // end corner moves up, ceiling at the frame limit
      sx  = (dbpf_pkg::PadW + 1)'(mid.x2) + (dbpf_pkg::PadW + 1)'(mid.pad);
      sy  = (dbpf_pkg::PadW + 1)'(mid.y2) + (dbpf_pkg::PadW + 1)'(mid.pad);
      nx2 = (sx > (dbpf_pkg::PadW + 1)'(limw)) ? limw : dbpf_pkg::CoordW'(sx);
      ny2 = (sy > (dbpf_pkg::PadW + 1)'(limh)) ? limh : dbpf_pkg::CoordW'(sy);

      bw = (nx2 > nx1) ? nx2 - nx1 : '0;
      bh = (ny2 > ny1) ? ny2 - ny1 : '0;

      kept = mid.pass &&
             (bw >= dbpf_pkg::CoordW'(1 << dbpf_pkg::CoordFracBits)) &&
             (bh >= dbpf_pkg::CoordW'(1 << dbpf_pkg::CoordFracBits));

      rsp.kept       = kept;
      rsp.box_left   = kept ? dbpf_pkg::OutW'(nx1) : '0;
      rsp.box_top    = kept ? dbpf_pkg::OutW'(ny1) : '0;
      rsp.box_width  = kept ? dbpf_pkg::OutW'(bw) : '0;
      rsp.box_height = kept ? dbpf_pkg::OutW'(bh) : '0;
      rsp.class_out  = kept ? mid.class_out : '0;
      rsp.confidence = kept ? mid.confidence : '0;
      rsp.frame_done = mid.eof;
   end

endmodule

// ----- sim/tb_detection_box_pad_filter_top.sv -----
module tb_detection_box_pad_filter_top;

   localparam int ClockHalf      = 10;
   localparam int ResetCycles    = 6;
   localparam int RunLimitCycles = 250000;
   localparam int RandomPhases   = 14;
   localparam int PhaseItems     = 100;
   localparam int PressurePhase  = 4;
   localparam int HoldCycles     = 120;
   localparam int DrainCycles    = 6;
   localparam int ReportLimit    = 10;

   // Indexes past the register list; writes there must change nothing
   localparam logic [dbpf_pkg::CsrIndexW-1:0] CsrSpareLow  = 3'd6;
   localparam logic [dbpf_pkg::CsrIndexW-1:0] CsrSpareHigh = 3'd7;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [dbpf_pkg::ReqDataW-1:0]   req_tdata = '0;
   logic                            req_tuser = 1'b0;
   logic                            req_tlast = 1'b0;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [dbpf_pkg::RspDataW-1:0]   rsp_tdata;
   logic                            rsp_tuser;
   logic                            rsp_tlast;
   logic                            csr_we = 1'b0;
   logic [dbpf_pkg::CsrIndexW-1:0]  csr_index = '0;
   logic [dbpf_pkg::CsrDataW-1:0]   csr_wdata = '0;

   detection_box_pad_filter_top u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #ClockHalf clock = 1'b1;
      #ClockHalf clock = 1'b0;
   end

   // Shadow of the block's registers and threshold table
   logic [dbpf_pkg::NetW-1:0]    net_w;
   logic [dbpf_pkg::NetW-1:0]    net_h;
   dbpf_pkg::pad_mode_type       pad_sel;
   logic [15:0]                  pad_px;
   logic [dbpf_pkg::FracW-1:0]   pad_frac;
   logic [7:0]                   class_count;
   logic [dbpf_pkg::ScoreW-1:0]  score_floor [0:dbpf_pkg::MaxClasses-1];

   dbpf_pkg::req_type  detection_pending [$];   // requests not yet accepted, head is on the bus
   dbpf_pkg::rsp_type  box_expect [$];          // predicted results, oldest first

   int  mismatch_count = 0;
   int  result_count = 0;
   bit  req_taken = 1'b1;
   int  burst_left = 8;
   int  gap_left = 0;
   int  ready_span = 0;
   logic [31:0] ready_pattern = '1;
   bit  rsp_hold = 1'b0;
   bit  pressure_go = 1'b0;
   dbpf_pkg::rsp_type seen;
   dbpf_pkg::rsp_type want;

   function automatic longint clip(input longint v, input longint hi);
      if (v > hi) v = hi;
      if (v < 0) v = 0;
      return v;
   endfunction

   function automatic longint larger(input longint a, input longint b);
      return (a > b) ? a : b;
   endfunction

   // Filter, clamp and pad one request against the shadow state; threshold writes
   // update the table and produce an all-zero result apart from frame_done.
   function automatic dbpf_pkg::rsp_type filter_detection(input dbpf_pkg::req_type d);
      longint  x1, y1, x2, y2, cls, n_valid, one;
      longint  lim_w, lim_h, w, h, margin, nx1, ny1, nx2, ny2, bw, bh;
      dbpf_pkg::rsp_type r;
      r = '0;
      r.frame_done = d.end_of_frame;
      cls = longint'($signed(d.class_index));
      if (d.cmd == dbpf_pkg::CmdThresh) begin
         if (cls >= 0 && cls < dbpf_pkg::MaxClasses) score_floor[int'(cls)] = d.score;
         return r;
      end
      n_valid = (class_count > dbpf_pkg::MaxClasses) ? longint'(dbpf_pkg::MaxClasses) :
                longint'(class_count);
      if (cls < 0 || cls >= n_valid) return r;
      if (d.score < score_floor[int'(cls)]) return r;

      lim_w = longint'(net_w) << dbpf_pkg::CoordFracBits;
      lim_h = longint'(net_h) << dbpf_pkg::CoordFracBits;
      x1 = clip(longint'($signed(d.x_start)), lim_w);
      y1 = clip(longint'($signed(d.y_start)), lim_h);
      x2 = clip(longint'($signed(d.x_end)), lim_w);
      y2 = clip(longint'($signed(d.y_end)), lim_h);
      w = larger(0, x2 - x1);
      h = larger(0, y2 - y1);

      case (pad_sel)
         dbpf_pkg::PadFixed: margin = longint'(pad_px);
         dbpf_pkg::PadFrame: margin = (longint'(pad_frac) * larger(lim_w, lim_h)) >> 16;
         dbpf_pkg::PadBox:   margin = (longint'(pad_frac) * larger(w, h)) >> 16;
         default:            margin = 0;
      endcase

      nx1 = clip(x1 - margin, lim_w);
      ny1 = clip(y1 - margin, lim_h);
      nx2 = clip(x2 + margin, lim_w);
      ny2 = clip(y2 + margin, lim_h);
      bw = larger(0, nx2 - nx1);
      bh = larger(0, ny2 - ny1);
      one = longint'(1) << dbpf_pkg::CoordFracBits;
      if (bw < one || bh < one)
         return r;

      r.kept       = 1'b1;
      r.box_left   = dbpf_pkg::OutW'(nx1);
      r.box_top    = dbpf_pkg::OutW'(ny1);
      r.box_width  = dbpf_pkg::OutW'(bw);
      r.box_height = dbpf_pkg::OutW'(bh);
      r.class_out  = dbpf_pkg::ClassOutW'(cls);
      r.confidence = d.score;
      return r;
   endfunction

   function automatic dbpf_pkg::req_type detection(input int xs, ys, xe, ye, sc, cls,
                                                   input bit eof);
      dbpf_pkg::req_type d;
      d.cmd          = dbpf_pkg::CmdDetect;
      d.x_start      = dbpf_pkg::XyW'(xs);
      d.y_start      = dbpf_pkg::XyW'(ys);
      d.x_end        = dbpf_pkg::XyW'(xe);
      d.y_end        = dbpf_pkg::XyW'(ye);
      d.score        = dbpf_pkg::ScoreW'(sc);
      d.class_index  = dbpf_pkg::ClassW'(cls);
      d.end_of_frame = eof;
      return d;
   endfunction

   // Threshold writes carry random corners, which the block must ignore, and a random frame flag
   function automatic dbpf_pkg::req_type threshold_write(input int cls, input int value);
      dbpf_pkg::req_type d;
      d = detection($urandom, $urandom, $urandom, $urandom, value, cls,
                    1'($urandom_range(1)));
      d.cmd = dbpf_pkg::CmdThresh;
      return d;
   endfunction

   // Mostly well-formed detections sized to the current frame, some table writes,
   // some raw noise over every bit of every field
   function automatic dbpf_pkg::req_type random_request();
      int kind, lim_x, lim_y, xs, ys, w, h, cls, n_valid, sc;
      kind  = $urandom_range(99);
      lim_x = int'(net_w) << dbpf_pkg::CoordFracBits;
      lim_y = int'(net_h) << dbpf_pkg::CoordFracBits;
      if (kind < 8) begin
         cls = ($urandom_range(7) == 0) ? int'($urandom) :
               $urandom_range(dbpf_pkg::MaxClasses - 1);
         sc  = ($urandom_range(9) == 0) ? 65536 : $urandom_range(45000);
         return threshold_write(cls, sc);
      end
      if (kind < 15)
         return detection($urandom, $urandom, $urandom, $urandom, $urandom_range(65536),
                          $urandom, 1'($urandom_range(1)));
      n_valid = (class_count > dbpf_pkg::MaxClasses) ? dbpf_pkg::MaxClasses :
                int'(class_count);
      cls = (n_valid == 0) ? $urandom_range(dbpf_pkg::MaxClasses - 1) :
            $urandom_range(n_valid - 1);
      if ($urandom_range(3) != 0) sc = $urandom_range(65536, score_floor[cls]);
      else sc = $urandom_range(65536);
      xs = $urandom_range(lim_x + 256) - 128;
      ys = $urandom_range(lim_y + 256) - 128;
      w  = $urandom_range(lim_x / 2 + 32);
      h  = $urandom_range(lim_y / 2 + 32);
      if ($urandom_range(15) == 0) w = -w;
      if ($urandom_range(15) == 0) h = -h;
      return detection(xs, ys, xs + w, ys + h, sc, cls, $urandom_range(7) == 0);
   endfunction

   function automatic logic [dbpf_pkg::CsrDataW-1:0] frame_side();
      case ($urandom_range(11))
         0:       return 16'd1;
         1:       return 16'd4095;
         2:       return 16'd0;
         3, 4:    return {4'($urandom), 12'($urandom)};
         default: return 16'($urandom_range(1920, 160));
      endcase
   endfunction

   // Append one request behind the ones already waiting
   task automatic enqueue(input dbpf_pkg::req_type d);
      detection_pending.insert(detection_pending.size(), d);
   endtask

   // Drive one register write at the falling edge, then mirror it once the
   // rising edge has taken it; only called while nothing is in flight
   task automatic write_reg(input logic [dbpf_pkg::CsrIndexW-1:0] idx,
                            input logic [dbpf_pkg::CsrDataW-1:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         dbpf_pkg::CsrNetWidth:    net_w = value[dbpf_pkg::NetW-1:0];
         dbpf_pkg::CsrNetHeight:   net_h = value[dbpf_pkg::NetW-1:0];
         dbpf_pkg::CsrPadMode:     pad_sel = dbpf_pkg::pad_mode_type'(value[1:0]);
         dbpf_pkg::CsrPadPixels:   pad_px = value;
         dbpf_pkg::CsrPadFraction: pad_frac = value;
         dbpf_pkg::CsrNumClasses:  class_count = value[7:0];
         default: ;
      endcase
   endtask

   task automatic random_setup();
      write_reg(dbpf_pkg::CsrNetWidth, frame_side());
      write_reg(dbpf_pkg::CsrNetHeight, frame_side());
      write_reg(dbpf_pkg::CsrPadMode, 16'($urandom));
      write_reg(dbpf_pkg::CsrPadPixels,
                16'(($urandom_range(1) == 0) ? $urandom_range(800) : $urandom));
      write_reg(dbpf_pkg::CsrPadFraction,
                16'(($urandom_range(1) == 0) ? $urandom_range(12000) : $urandom));
      case ($urandom_range(3))
         0:       write_reg(dbpf_pkg::CsrNumClasses, 16'(dbpf_pkg::MaxClasses));
         1:       write_reg(dbpf_pkg::CsrNumClasses, 16'($urandom));
         default: write_reg(dbpf_pkg::CsrNumClasses,
                            16'($urandom_range(dbpf_pkg::MaxClasses, 1)));
      endcase
   endtask

   // Wait for every request to be taken and every result to come back, then let
   // the three pipeline stages run empty before touching registers
   task automatic settle();
      while (detection_pending.size() != 0 || box_expect.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic compare_field(input string name, input logic [16:0] exp_v,
                                input logic [16:0] got_v);
      if (exp_v !== got_v) begin
         mismatch_count++;
         if (mismatch_count <= ReportLimit)
            $display("result %0d: %s expected %0h, got %0h", result_count, name, exp_v, got_v);
      end
   endtask

   // Request driver: advance at the falling edge, hold the bus until the
   // handshake, then pause for a random gap after each burst
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (req_tvalid && !req_taken) begin
         // hold the current request
      end else if (gap_left > 0) begin
         gap_left--;
         req_tvalid <= 1'b0;
      end else if (detection_pending.size() != 0) begin
         req_tdata  <= {7'd0, detection_pending[0].class_index, detection_pending[0].score,
                        detection_pending[0].y_end, detection_pending[0].x_end,
                        detection_pending[0].y_start, detection_pending[0].x_start};
         req_tuser  <= detection_pending[0].cmd;
         req_tlast  <= detection_pending[0].end_of_frame;
         req_tvalid <= 1'b1;
         req_taken = 1'b0;
         burst_left--;
         if (burst_left <= 0) begin
            burst_left = $urandom_range(24, 1);
            gap_left   = ($urandom_range(2) == 0) ? 0 : $urandom_range(6, 1);
         end
      end else begin
         req_tvalid <= 1'b0;
      end
   end

   // Request acceptance: predict the result before dropping the request
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) begin
         box_expect.insert(box_expect.size(), filter_detection(detection_pending[0]));
         void'(detection_pending.pop_front());
         req_taken = 1'b1;
      end
   end

   // Result receiver: rotate a stall pattern, reload it now and then, and
   // force it low while a long hold-off is active
   always @(negedge clock) begin
      if (ready_span <= 0) begin
         ready_span = $urandom_range(96, 32);
         case ($urandom_range(3))
            0:       ready_pattern = '1;
            1:       ready_pattern = $urandom;
            default: ready_pattern = $urandom | $urandom;
         endcase
      end
      ready_span--;
      ready_pattern = {ready_pattern[0], ready_pattern[31:1]};
      rsp_tready <= ready_pattern[0] && !rsp_hold;
   end

   // Long hold-off: back-pressure the output so the pipeline fills and
   // req_tready has to drop while the sender keeps offering
   initial begin
      wait (pressure_go);
      @(posedge clock);
      rsp_hold = 1'b1;
      repeat (HoldCycles) @(posedge clock);
      rsp_hold = 1'b0;
   end

   // Result monitor: compare each accepted result with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         result_count++;
         seen.kept       = rsp_tuser;
         seen.box_left   = rsp_tdata[15:0];
         seen.box_top    = rsp_tdata[31:16];
         seen.box_width  = rsp_tdata[47:32];
         seen.box_height = rsp_tdata[63:48];
         seen.class_out  = rsp_tdata[70:64];
         seen.confidence = rsp_tdata[87:71];
         seen.frame_done = rsp_tlast;
         if (box_expect.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= ReportLimit)
               $display("result %0d: no result expected, got %0h", result_count, seen);
         end else begin
            want = box_expect.pop_front();
            compare_field("kept", 17'(want.kept), 17'(seen.kept));
            compare_field("box_left", 17'(want.box_left), 17'(seen.box_left));
            compare_field("box_top", 17'(want.box_top), 17'(seen.box_top));
            compare_field("box_width", 17'(want.box_width), 17'(seen.box_width));
            compare_field("box_height", 17'(want.box_height), 17'(seen.box_height));
            compare_field("class_out", 17'(want.class_out), 17'(seen.class_out));
            compare_field("confidence", want.confidence, seen.confidence);
            compare_field("frame_done", 17'(want.frame_done), 17'(seen.frame_done));
         end
      end
   end

   // Stimulus: directed corner cases first, then randomized phases with a
   // fresh register setting each
   initial begin
      int phase;
      net_w       = dbpf_pkg::CfgRst.net_width;
      net_h       = dbpf_pkg::CfgRst.net_height;
      pad_sel     = dbpf_pkg::CfgRst.pad_mode;
      pad_px      = dbpf_pkg::CfgRst.margin_px;
      pad_frac    = dbpf_pkg::CfgRst.pad_fraction;
      class_count = dbpf_pkg::CfgRst.num_classes;
      foreach (score_floor[i]) score_floor[i] = '0;

      repeat (ResetCycles) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset settings: threshold table writes, rejected table indexes, the
      // threshold boundary, class range edges, extreme corners, inverted and empty boxes
      enqueue(threshold_write(3, 30000));
      enqueue(threshold_write(127, 65536));
      enqueue(threshold_write(-1, 5));
      enqueue(threshold_write(dbpf_pkg::MaxClasses, 7));
      enqueue(detection(1600, 1600, 3200, 3200, 29999, 3, 0));
      enqueue(detection(1600, 1600, 3200, 3200, 30000, 3, 0));
      enqueue(detection(100, 200, 900, 500, 0, 0, 1));
      enqueue(detection(-524288, -524288, 524287, 524287, 40000, 79, 0));
      enqueue(detection(100, 100, 900, 900, 40000, 80, 0));
      enqueue(detection(100, 100, 900, 900, 40000, -32768, 0));
      enqueue(detection(100, 100, 900, 900, 40000, 32767, 0));
      enqueue(detection(900, 100, 100, 900, 40000, 1, 0));
      enqueue(detection(0, 0, 10240, 10240, 65536, 2, 1));
      enqueue(detection(1600, 1600, 1600, 1600, 500, 4, 0));
      settle();

      // Wide, one-pixel-high frame with no margin; class count past the table;
      // upper data bits and spare indexes must be ignored
      write_reg(dbpf_pkg::CsrPadMode, {14'h3FFF, dbpf_pkg::PadNone});
      write_reg(dbpf_pkg::CsrNetWidth, {4'hF, 12'd4095});
      write_reg(dbpf_pkg::CsrNetHeight, 16'd1);
      write_reg(dbpf_pkg::CsrNumClasses, {8'hAB, 8'd255});
      write_reg(dbpf_pkg::CsrPadPixels, 16'hFFFF);
      write_reg(dbpf_pkg::CsrPadFraction, 16'h0000);
      write_reg(CsrSpareLow, 16'h0000);
      write_reg(CsrSpareHigh, 16'hFFFF);
      enqueue(detection(0, 0, 65520, 16, 65536, 127, 0));
      enqueue(detection(0, 0, 100, 16, 65535, 127, 0));
      enqueue(detection(0, 8, 100, 16, 100, 100, 0));
      enqueue(detection(-524288, -524288, 524287, 524287, 1, 120, 1));
      settle();

      // Zero frame width drops everything
      write_reg(dbpf_pkg::CsrPadMode, 16'(dbpf_pkg::PadFixed));
      write_reg(dbpf_pkg::CsrNetWidth, 16'd0);
      enqueue(detection(16, 0, 200, 16, 10, 5, 1));
      settle();

      // Full margin of the largest frame; no valid classes, then exactly one
      write_reg(dbpf_pkg::CsrNetWidth, 16'd4095);
      write_reg(dbpf_pkg::CsrNetHeight, 16'd4095);
      write_reg(dbpf_pkg::CsrPadMode, 16'(dbpf_pkg::PadFrame));
      write_reg(dbpf_pkg::CsrPadFraction, 16'hFFFF);
      write_reg(dbpf_pkg::CsrNumClasses, 16'd0);
      enqueue(detection(5000, 5000, 5100, 5100, 0, 0, 0));
      settle();
      write_reg(dbpf_pkg::CsrNumClasses, 16'd1);
      enqueue(detection(5000, 5000, 5100, 5100, 0, 0, 1));
      settle();

      for (phase = 0; phase < RandomPhases; phase++) begin
         random_setup();
         if (phase == PressurePhase) pressure_go = 1'b1;
         repeat (PhaseItems) enqueue(random_request());
         settle();
      end

      if (mismatch_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // Watchdog: end a hung run
   initial begin
      #(RunLimitCycles * 2 * ClockHalf);
      $display("Verification failed");
      $finish;
   end

endmodule

// ----- files.f -----
design/dbpf_pkg.sv
design/dbpf_ram.sv
design/dbpf_clip.sv
design/dbpf_pad.sv
design/detection_box_pad_filter_top.sv
sim/tb_detection_box_pad_filter_top.sv
